// ===== rtl/core/tmw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmw_pkg: shared constants for the trimmed-mean window filter
// Sample width and default window length used by the top level and the cells.
// ----------------------------------------------------------------------------
package tmw_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int WINDOW_LEN_DEF = 10;

endpackage

// ===== rtl/core/trimmed_mean_window_filter.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter: sliding-window trimmed mean
// Mean of the last WINDOW_LEN samples with one minimum and one maximum dropped.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid / req_stall / req_sample carries one 16-bit
//   unsigned sample per request. Each request yields exactly one response on
//   rsp_valid / rsp_stall / rsp_filtered, in request order.
//   The window is a chain of sorted cells (slot 0 holds the minimum, the last
//   slot the maximum) plus a running sum; a request updates both in the same cycle.
//   Pipeline: a request passes the cells, trim subtract, reciprocal multiply,
//   remainder and correction registers before rsp_valid rises.
//   Throughput: one request per clock unless the response side stalls; the cell
//   chain takes a new sample every unstalled cycle and the divider behind it is fully pipelined.
//   Stall: while rsp_valid is high and rsp_stall is high the whole pipeline
//   holds and req_stall is raised in the same cycle.
//   Reset: synchronous, active high. The window fills with zeros, which count
//   as samples until pushed out, and the pipeline empties.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter #(
   parameter int WINDOW_LEN = tmw_pkg::WINDOW_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tmw_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tmw_pkg::SAMPLE_W-1:0]  rsp_filtered
);

   localparam int SW    = tmw_pkg::SAMPLE_W;
   localparam int AGE_W = $clog2(WINDOW_LEN);
   localparam int SUM_W = SW + $clog2(WINDOW_LEN);
   localparam int DIV   = WINDOW_LEN - 2;

   logic             advance, accept;
   logic             v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;

   logic [SW-1:0]    win_ff [WINDOW_LEN];
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] diff_ff, diff_in;

   logic [SW-1:0]    cell_v   [WINDOW_LEN];
   logic [AGE_W-1:0] cell_age [WINDOW_LEN];
   logic             cell_g   [WINDOW_LEN];
   logic [SW-1:0]    cell_c   [WINDOW_LEN];
   logic [AGE_W-1:0] cell_cag [WINDOW_LEN];
   logic             cell_gtc [WINDOW_LEN];
   logic             cell_dp  [WINDOW_LEN];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign rsp_valid = rsp_valid_ff;

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      logic [SW-1:0]    lc, rv;
      logic [AGE_W-1:0] lc_age, r_age;
      logic             l_gtc, l_dp, r_g;

      if (i == 0) begin : g_left_end
         assign lc     = '0;
         assign lc_age = '0;
         assign l_gtc  = 1'b0;
         assign l_dp   = 1'b0;
      end else begin : g_left
         assign lc     = cell_c[i-1];
         assign lc_age = cell_cag[i-1];
         assign l_gtc  = cell_gtc[i-1];
         assign l_dp   = cell_dp[i-1];
      end

      if (i == WINDOW_LEN - 1) begin : g_right_end
         assign rv    = '0;
         assign r_age = '0;
         assign r_g   = 1'b1;
      end else begin : g_right
         assign rv    = cell_v[i+1];
         assign r_age = cell_age[i+1];
         assign r_g   = cell_g[i+1];
      end

      tmw_cell #(
         .AGE_W     (AGE_W),
         .OLDEST    (WINDOW_LEN - 1),
         .RESET_AGE (WINDOW_LEN - 1 - i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .sample     (req_sample),
         .left_c     (lc),
         .left_c_age (lc_age),
         .left_gtc   (l_gtc),
         .dp_in      (l_dp),
         .right_v    (rv),
         .right_age  (r_age),
         .right_g    (r_g),
         .val        (cell_v[i]),
         .age        (cell_age[i]),
         .g_out      (cell_g[i]),
         .c_out      (cell_c[i]),
         .c_age_out  (cell_cag[i]),
         .gtc_out    (cell_gtc[i]),
         .dp_out     (cell_dp[i])
      );
   end

   // arrival-order taps give the sample that drops out of the running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WINDOW_LEN; j++) begin
            win_ff[j] <= '0;
         end
      end else if (accept) begin
         for (int j = 0; j < WINDOW_LEN - 1; j++) begin
            win_ff[j] <= win_ff[j+1];
         end
         win_ff[WINDOW_LEN-1] <= req_sample;
      end
   end

   assign sum_in  = sum_ff + SUM_W'(req_sample) - SUM_W'(win_ff[0]);
   assign diff_in = sum_ff - SUM_W'(cell_v[0]) - SUM_W'(cell_v[WINDOW_LEN-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (accept) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v0_ff        <= accept;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   tmw_div #(
      .IN_W    (SUM_W),
      .DIVISOR (DIV)
   ) u_div (
      .clock    (clock),
      .en       (advance),
      .dividend (diff_ff),
      .quotient (rsp_filtered)
   );

   // exactly one slot always carries the oldest age, so the chain closes up once
   a_oldest_found: assert property (@(posedge clock) disable iff (reset)
      cell_dp[WINDOW_LEN-1])
      else $error("no oldest entry in cell chain");

   a_sorted_ends: assert property (@(posedge clock) disable iff (reset)
      cell_v[0] <= cell_v[WINDOW_LEN-1])
      else $error("cell chain minimum above maximum");

   a_sum_covers_ends: assert property (@(posedge clock) disable iff (reset)
      sum_ff >= SUM_W'(cell_v[0]) + SUM_W'(cell_v[WINDOW_LEN-1]))
      else $error("running sum below trimmed ends");

   a_request_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> v0_ff)
      else $error("accepted request not tracked in pipeline");

   a_stall_holds_cells: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(sum_ff) && $stable(cell_v[0]))
      else $error("window changed while stalled");

endmodule

// ===== rtl/core/tmw_cell.sv =====
// ----------------------------------------------------------------------------
// tmw_cell: one slot of the sorted window chain
// Holds one sample and its age. On each request the oldest sample leaves the
// chain and the new one drops into its sorted place; every cell decides its
// next content from its own slot and its two neighbors.
// ----------------------------------------------------------------------------
module tmw_cell #(
   parameter int AGE_W     = 4,
   parameter int OLDEST    = 9,
   parameter int RESET_AGE = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [tmw_pkg::SAMPLE_W-1:0]  sample,
   // from left neighbor (compacted slot)
   input  logic [tmw_pkg::SAMPLE_W-1:0]  left_c,
   input  logic [AGE_W-1:0]              left_c_age,
   input  logic                          left_gtc,
   input  logic                          dp_in,
   // from right neighbor (raw slot)
   input  logic [tmw_pkg::SAMPLE_W-1:0]  right_v,
   input  logic [AGE_W-1:0]              right_age,
   input  logic                          right_g,
   // to neighbors
   output logic [tmw_pkg::SAMPLE_W-1:0]  val,
   output logic [AGE_W-1:0]              age,
   output logic                          g_out,
   output logic [tmw_pkg::SAMPLE_W-1:0]  c_out,
   output logic [AGE_W-1:0]              c_age_out,
   output logic                          gtc_out,
   output logic                          dp_out
);

   logic [tmw_pkg::SAMPLE_W-1:0] val_ff, val_in;
   logic [AGE_W-1:0]             age_ff, age_in;
   logic                         dp_at;

   assign val   = val_ff;
   assign age   = age_ff;
   assign g_out = val_ff > sample;

   // dp_at: the oldest entry sits here or further left, so this slot closes up
   assign dp_at     = dp_in | (age_ff == AGE_W'(OLDEST));
   assign dp_out    = dp_at;
   assign c_out     = dp_at ? right_v : val_ff;
   assign c_age_out = dp_at ? right_age : age_ff;
   assign gtc_out   = dp_at ? right_g : g_out;

   always_comb begin
      if (!gtc_out) begin
         val_in = c_out;
         age_in = c_age_out + AGE_W'(1);
      end else if (!left_gtc) begin
         val_in = sample;
         age_in = '0;
      end else begin
         val_in = left_c;
         age_in = left_c_age + AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= AGE_W'(RESET_AGE);
      end else if (shift_en) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

endmodule

// ===== rtl/core/tmw_div.sv =====
// ----------------------------------------------------------------------------
// tmw_div: divide by a constant
// Three stages: multiply by the truncated reciprocal, take the quotient
// estimate and its remainder, then add one where the remainder is too big.
// ----------------------------------------------------------------------------
module tmw_div #(
   parameter int IN_W    = 20,
   parameter int DIVISOR = 8
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [IN_W-1:0]              dividend,
   output logic [tmw_pkg::SAMPLE_W-1:0] quotient
);

   localparam int                 REM_W = (2 * DIVISOR > 1) ? $clog2(2 * DIVISOR) : 1;
   localparam logic [IN_W:0]      RECIP = (IN_W + 1)'((64'd1 << IN_W) / DIVISOR);
   localparam logic [REM_W-1:0]   DIV_R = REM_W'(DIVISOR);

   logic [2*IN_W:0]               prod_ff, prod_in;
   logic [IN_W-1:0]               num_ff;
   logic [tmw_pkg::SAMPLE_W-1:0]  q0_ff, q0_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [IN_W-1:0]               rem_full;
   logic [tmw_pkg::SAMPLE_W-1:0]  quot_ff, quot_in;

   assign prod_in = (2*IN_W+1)'(dividend) * (2*IN_W+1)'(RECIP);

   // estimate is low by at most one, so the remainder stays below twice the divisor
   assign q0_in    = tmw_pkg::SAMPLE_W'(prod_ff >> IN_W);
   assign rem_full = num_ff - IN_W'(q0_in) * IN_W'(DIVISOR);
   assign rem_in   = rem_full[REM_W-1:0];

   assign quot_in  = (rem_ff >= DIV_R) ? q0_ff + tmw_pkg::SAMPLE_W'(1) : q0_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         num_ff  <= dividend;
         q0_ff   <= q0_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

endmodule

// ===== verif/trimmed_mean_window_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_test: self-checking bench for the trimmed mean
// Streams 16-bit samples into the filter with bursty requests and a patterned
// response stall, and checks every filtered value against a local model of the
// sliding window (sorted ends dropped, truncated mean of the rest).
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_test;

   localparam int WIN_LEN      = tmw_pkg::WINDOW_LEN_DEF;
   localparam int SW           = tmw_pkg::SAMPLE_W;
   localparam int RANDOM_COUNT = 450;
   localparam int STEADY_COUNT = 120;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 20;

   // Window model and the queue of filtered values still owed by the block.
   class filter_window_board;
      logic [SW-1:0] window [WIN_LEN];
      logic [SW-1:0] filtered_due [$];
      int            fault_count;

      function new();
         foreach (window[i]) window[i] = '0;
         fault_count = 0;
      endfunction

      function void note_sample(logic [SW-1:0] sample);
         logic [31:0]   total;
         logic [SW-1:0] lo;
         logic [SW-1:0] hi;
         for (int i = 0; i < WIN_LEN - 1; i++) window[i] = window[i + 1];
         window[WIN_LEN - 1] = sample;
         total = '0;
         lo    = window[0];
         hi    = window[0];
         foreach (window[i]) begin
            total += 32'(window[i]);
            if (window[i] < lo) lo = window[i];
            if (window[i] > hi) hi = window[i];
         end
         // dropping one min and one max equals trimming the sorted ends
         total = total - 32'(lo) - 32'(hi);
         filtered_due.push_back(SW'(total / 32'(WIN_LEN - 2)));
      endfunction

      function void check_filtered(logic [SW-1:0] got);
         logic [SW-1:0] want;
         if (filtered_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("response with no request pending: filtered=%0d", got);
            return;
         end
         want = filtered_due.pop_front();
         if (got !== want) begin
            fault_count++;
            if (fault_count <= 10)
               $display("filtered mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int pending();
         return filtered_due.size();
      endfunction
   endclass

   logic          clock;
   logic          reset      = 1'b1;
   logic          req_valid  = 1'b0;
   logic          req_stall;
   logic [SW-1:0] req_sample = '0;
   logic          rsp_valid;
   logic          rsp_stall  = 1'b0;
   logic [SW-1:0] rsp_filtered;

   filter_window_board board = new();

   int            burst_left  = 0;
   bit            steady      = 1'b1;
   bit            quiet_rx    = 1'b1;
   logic [15:0]   stall_mask  = '0;
   logic [3:0]    stall_phase = '0;
   int            idle_cycles = 0;
   logic [SW-1:0] last_sample = '0;

   trimmed_mean_window_filter i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stall: a 16-bit mask of varying density, redrawn each lap.
   always @(posedge clock) begin
      if (reset || quiet_rx) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall   <= stall_mask[stall_phase];
         stall_phase <= stall_phase + 4'd1;
         if (stall_phase == 4'd15) begin
            case ($urandom_range(0, 3))
               0: stall_mask <= '0;
               1: stall_mask <= 16'($urandom & $urandom & $urandom);
               2: stall_mask <= 16'($urandom & $urandom);
               default: stall_mask <= 16'($urandom);
            endcase
         end
      end
   end

   // Request/response monitor and inactivity watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         // note first: a response in the same cycle as its request would still find its entry
         if (req_valid && !req_stall) board.note_sample(req_sample);
         if (rsp_valid && !rsp_stall) board.check_filtered(rsp_filtered);
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_sample(input logic [SW-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = 0;
         if (!steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      last_sample = value;
   endtask

   function automatic logic [SW-1:0] pick_sample();
      logic [SW-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = SW'($urandom);
         4: v = SW'($urandom_range(0, 15));
         5: v = SW'(16'hFFFF - $urandom_range(0, 15));
         6: v = last_sample;                          // ties
         7: begin
            v = SW'(1) << $urandom_range(0, SW - 1);
            if ($urandom_range(0, 1)) v = ~v;
         end
         8: v = $urandom_range(0, 1) ? '1 : '0;
         default: v = last_sample + SW'($urandom_range(0, 64)) - SW'(32);
      endcase
      return v;
   endfunction

   initial begin
      logic [SW-1:0] directed [$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // startup zeros, then a window full of the maximum, then ties and edges
      directed = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'h0000, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
                   16'h7FFF, 16'h1234, 16'h1234, 16'h1234, 16'h0000,
                   16'h0000, 16'h0000};
      foreach (directed[i]) send_sample(directed[i]);

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == STEADY_COUNT / 2) quiet_rx = 1'b0;
         if (n == STEADY_COUNT) steady = 1'b0;
         send_sample(pick_sample());
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
